// ----- design/assert_macros.svh -----
// Assertion helpers used by the datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Invariant that holds at every clock edge out of reset.
`define KJDQ_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Same-cycle implication.
`define KJDQ_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ----- design/kjdq_pkg.sv -----
package kjdq_pkg;

	localparam logic [1:0] FUNC_PUSH    = 2'd0;
	localparam logic [1:0] FUNC_TAKE    = 2'd1;
	localparam logic [1:0] FUNC_RELEASE = 2'd2;
	localparam logic [1:0] FUNC_UNUSED  = 2'd3;

	localparam int KEY_W    = 64;
	localparam int TAG_IN_W = 16;
	localparam int QCNT_W   = 7;
	localparam int RCNT_W   = 3;

	typedef struct packed {
		logic capture;
		logic push;
		logic release_key;
		logic rd_scan;
		logic advance;
		logic hit;
		logic rd_shift;
		logic wr_shift;
		logic finish_take;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic is_push;
		logic is_take;
		logic is_release;
		logic empty;
		logic match;
		logic scan_end;
		logic shift_end;
	} sts_t;

endpackage

// ----- design/kjdq_if.sv -----
interface kjdq_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         func;
	logic signed [63:0] job_key;
	logic [15:0]        job_tag;
	logic               is_quick;
	logic               want_quick;

	modport source (output valid, func, job_key, job_tag, is_quick, want_quick, input ready);
	modport sink (input valid, func, job_key, job_tag, is_quick, want_quick, output ready);
endinterface

interface kjdq_rsp_if;
	logic               valid;
	logic               ready;
	logic               ok;
	logic signed [63:0] out_key;
	logic [15:0]        out_tag;
	logic [6:0]         queued_count;
	logic [2:0]         running_count;

	modport source (output valid, ok, out_key, out_tag, queued_count, running_count, input ready);
	modport sink (input valid, ok, out_key, out_tag, queued_count, running_count, output ready);
endinterface

// ----- design/kjdq_ram.sv -----
module kjdq_ram #(
	parameter int WIDTH = 81,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- design/kjdq_ctrl.sv -----
module kjdq_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	input  kjdq_pkg::sts_t sts,
	output kjdq_pkg::cmd_t cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DISP = 3'd1;
	localparam logic [2:0] ST_CHK  = 3'd2;
	localparam logic [2:0] ST_SHW  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	logic [2:0] state_q, state_d;
	logic       out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_DISP;
				end
			end
			ST_DISP: begin
				priority if (sts.is_push) begin
					cmd.push = 1'b1;
					state_d  = ST_FIN;
				end else if (sts.is_release) begin
					cmd.release_key = 1'b1;
					state_d         = ST_FIN;
				end else if (sts.is_take && !sts.empty) begin
					cmd.rd_scan = 1'b1;
					state_d     = ST_CHK;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_CHK: begin
				if (sts.match) begin
					cmd.hit = 1'b1;
					if (sts.scan_end) begin
						cmd.finish_take = 1'b1;
						state_d         = ST_FIN;
					end else begin
						cmd.rd_shift = 1'b1;
						state_d      = ST_SHW;
					end
				end else if (sts.scan_end) begin
					state_d = ST_FIN;
				end else begin
					cmd.advance = 1'b1;
				end
			end
			ST_SHW: begin
				cmd.wr_shift = 1'b1;
				if (sts.shift_end) begin
					cmd.finish_take = 1'b1;
					state_d         = ST_FIN;
				end else begin
					cmd.rd_shift = 1'b1;
				end
			end
			ST_FIN: begin
				if (!out_valid_q || rsp_ready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = out_valid_q;

endmodule

// ----- design/kjdq_dp.sv -----
`include "assert_macros.svh"

module kjdq_dp #(
	parameter int QUEUE_DEPTH = 64,
	parameter int RUN_SLOTS   = 4,
	parameter int TAG_BITS    = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  kjdq_pkg::cmd_t     cmd,
	output kjdq_pkg::sts_t     sts,
	input  logic [1:0]         func,
	input  logic signed [63:0] job_key,
	input  logic [15:0]        job_tag,
	input  logic               is_quick,
	input  logic               want_quick,
	output logic               ok,
	output logic signed [63:0] out_key,
	output logic [15:0]        out_tag,
	output logic [6:0]         queued_count,
	output logic [2:0]         running_count
);

	localparam int AW  = $clog2(QUEUE_DEPTH);
	localparam int FW  = $clog2(QUEUE_DEPTH + 1);
	localparam int RFW = $clog2(RUN_SLOTS + 1);
	localparam int RIW = (RUN_SLOTS > 1) ? $clog2(RUN_SLOTS) : 1;
	localparam int KW  = kjdq_pkg::KEY_W;
	localparam int WW  = KW + TAG_BITS + 1;

	// captured operation
	logic [1:0]          func_q;
	logic [KW-1:0]       key_q;
	logic [TAG_BITS-1:0] tag_q;
	logic                quick_q;
	logic                qonly_q;

	logic [FW-1:0]       fill_q;
	logic [RFW-1:0]      rfill_q;
	logic [KW-1:0]       run_key_q [RUN_SLOTS];
	logic [FW-1:0]       idx_q, idx_d;

	logic                res_ok_q;
	logic [KW-1:0]       fkey_q;
	logic [TAG_BITS-1:0] ftag_q;

	logic                ok_q;
	logic [KW-1:0]       out_key_q;
	logic [15:0]         out_tag_q;
	logic [6:0]          qcnt_q;
	logic [2:0]          rcnt_q;

	logic                we, re;
	logic [AW-1:0]       waddr, raddr;
	logic [WW-1:0]       wdata, rdata;
	logic [FW:0]         raddr_sum;

	logic [KW-1:0]       rd_key;
	logic [TAG_BITS-1:0] rd_tag;
	logic                rd_quick;
	logic                running;
	logic                full;
	logic [FW:0]         idx_p1, idx_p2;

	logic                rel_found;
	logic [RIW-1:0]      rel_idx;
	logic [KW-1:0]       last_key;
	logic [KW-1:0]       take_key;

	logic [TAG_BITS+15:0] tag_ext, tag_oext;
	logic [FW+6:0]        qcnt_ext;
	logic [RFW+2:0]       rcnt_ext;

	assign tag_ext  = {{TAG_BITS{1'b0}}, job_tag};
	assign tag_oext = {16'b0, ftag_q};
	assign qcnt_ext = {7'b0, fill_q};
	assign rcnt_ext = {3'b0, rfill_q};

	assign full   = (fill_q == FW'(QUEUE_DEPTH));
	assign idx_p1 = {1'b0, idx_q} + (FW+1)'(1);
	assign idx_p2 = {1'b0, idx_q} + (FW+1)'(2);

	assign rd_key   = rdata[KW-1:0];
	assign rd_tag   = rdata[KW +: TAG_BITS];
	assign rd_quick = rdata[WW-1];

	always_comb begin
		running = 1'b0;
		for (int j = 0; j < RUN_SLOTS; j++) begin
			if (rfill_q > RFW'(j) && run_key_q[j] == rd_key) begin
				running = 1'b1;
			end
		end
	end

	always_comb begin
		rel_found = 1'b0;
		rel_idx   = '0;
		last_key  = '0;
		for (int j = 0; j < RUN_SLOTS; j++) begin
			if (!rel_found && rfill_q > RFW'(j) && run_key_q[j] == key_q) begin
				rel_found = 1'b1;
				rel_idx   = RIW'(j);
			end
			if (rfill_q == RFW'(j + 1)) begin
				last_key = run_key_q[j];
			end
		end
	end

	assign take_key = cmd.hit ? rd_key : fkey_q;

	always_comb begin
		if (cmd.capture) begin
			idx_d = '0;
		end else if (cmd.advance || cmd.wr_shift) begin
			idx_d = idx_q + FW'(1);
		end else begin
			idx_d = idx_q;
		end
	end

	// queue storage
	assign we        = (cmd.push && !full) || cmd.wr_shift;
	assign waddr     = cmd.push ? fill_q[AW-1:0] : idx_q[AW-1:0];
	assign wdata     = cmd.push ? {quick_q, tag_q, key_q} : rdata;
	assign re        = cmd.rd_scan || cmd.advance || cmd.rd_shift;
	assign raddr_sum = {1'b0, idx_d} + (cmd.rd_shift ? (FW+1)'(1) : (FW+1)'(0));
	assign raddr     = raddr_sum[AW-1:0];

	kjdq_ram #(
		.WIDTH(WW),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			rfill_q <= '0;
		end else begin
			if (cmd.push && !full) begin
				fill_q <= fill_q + FW'(1);
			end else if (cmd.finish_take) begin
				fill_q <= fill_q - FW'(1);
			end
			if (cmd.finish_take && rfill_q < RFW'(RUN_SLOTS)) begin
				rfill_q <= rfill_q + RFW'(1);
			end else if (cmd.release_key && rel_found) begin
				rfill_q <= rfill_q - RFW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		if (cmd.capture) begin
			func_q   <= func;
			key_q    <= job_key;
			tag_q    <= tag_ext[TAG_BITS-1:0];
			quick_q  <= is_quick;
			qonly_q  <= want_quick;
			res_ok_q <= 1'b0;
			fkey_q   <= '0;
			ftag_q   <= '0;
		end
		if ((cmd.push && !full) || (cmd.release_key && rel_found)) begin
			res_ok_q <= 1'b1;
		end
		if (cmd.hit) begin
			res_ok_q <= 1'b1;
			fkey_q   <= rd_key;
			ftag_q   <= rd_tag;
		end
		for (int j = 0; j < RUN_SLOTS; j++) begin
			if (cmd.release_key && rel_found && rel_idx == RIW'(j)) begin
				run_key_q[j] <= last_key;
			end
			if (cmd.finish_take && rfill_q == RFW'(j)) begin
				run_key_q[j] <= take_key;
			end
		end
		if (cmd.load_out) begin
			ok_q      <= res_ok_q;
			out_key_q <= fkey_q;
			out_tag_q <= tag_oext[15:0];
			qcnt_q    <= qcnt_ext[6:0];
			rcnt_q    <= rcnt_ext[2:0];
		end
	end

	assign sts.is_push    = (func_q == kjdq_pkg::FUNC_PUSH);
	assign sts.is_take    = (func_q == kjdq_pkg::FUNC_TAKE);
	assign sts.is_release = (func_q == kjdq_pkg::FUNC_RELEASE);
	assign sts.empty      = (fill_q == '0);
	assign sts.match      = !(qonly_q && !rd_quick) && !running;
	assign sts.scan_end   = (idx_p1 >= {1'b0, fill_q});
	assign sts.shift_end  = (idx_p2 >= {1'b0, fill_q});

	assign ok            = ok_q;
	assign out_key       = out_key_q;
	assign out_tag       = out_tag_q;
	assign queued_count  = qcnt_q;
	assign running_count = rcnt_q;

	`KJDQ_ASSERT(a_fill_bound, fill_q <= FW'(QUEUE_DEPTH), "queue fill beyond depth")
	`KJDQ_ASSERT(a_rfill_bound, rfill_q <= RFW'(RUN_SLOTS), "running fill beyond slots")
	`KJDQ_ASSERT_IMP(a_shift_in_range, cmd.wr_shift, idx_p1 < {1'b0, fill_q}, "shift past fill")

endmodule

// ----- design/keyed_job_dispatch_queue.sv -----
// Push, release, unused codes and a take on an empty queue go from accept through the
// dispatch and finish states. Take: the check state visits each entry scanned up to
//   the chosen job, then the shift state moves each entry behind it down through the
//   queue RAM. One item at a time: the finish state stalls until the output register
//   is free, and the next item is accepted while a result waits.
// Reset: arst_n clears queue fill, running fill and handshake state; RAM is not cleared.
module keyed_job_dispatch_queue #(
	parameter int QUEUE_DEPTH = 64,
	parameter int RUN_SLOTS   = 4,
	parameter int TAG_BITS    = 16
) (
	input logic        clk,
	input logic        arst_n,
	kjdq_req_if.sink   req,
	kjdq_rsp_if.source rsp
);

	// controller <-> datapath
	kjdq_pkg::cmd_t cmd;
	kjdq_pkg::sts_t sts;

	// State machine: idle, dispatch, scan/check, shift, finish.
	kjdq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.req_ready(req.ready),
		.rsp_valid(rsp.valid),
		.rsp_ready(rsp.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Queue RAM, running-key slots, counters and the result register.
	kjdq_dp #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.RUN_SLOTS  (RUN_SLOTS),
		.TAG_BITS   (TAG_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.func         (req.func),
		.job_key      (req.job_key),
		.job_tag      (req.job_tag),
		.is_quick     (req.is_quick),
		.want_quick   (req.want_quick),
		.ok           (rsp.ok),
		.out_key      (rsp.out_key),
		.out_tag      (rsp.out_tag),
		.queued_count (rsp.queued_count),
		.running_count(rsp.running_count)
	);

endmodule
